>>> hw/rtl/ucd_pkg.sv
// shared types and constants of the code point decoder
// used by ucd_front, ucd_queue, ucd_back and utf_codepoint_decoder_unit
package ucd_pkg;

    // encoding register codes, code 3 decodes as utf-32
    localparam logic [1:0] ENC_UTF8  = 2'd0;
    localparam logic [1:0] ENC_UTF16 = 2'd1;
    localparam logic [1:0] ENC_UTF32 = 2'd2;

    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] MIN_3BYTE   = 21'h000800;
    localparam logic [20:0] MIN_4BYTE   = 21'h010000;
    localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;
    localparam logic [15:0] HI_SURR_LO  = 16'hD800;
    localparam logic [15:0] HI_SURR_HI  = 16'hDBFF;
    localparam logic [15:0] LO_SURR_LO  = 16'hDC00;
    localparam logic [15:0] LO_SURR_HI  = 16'hDFFF;
    localparam logic [31:0] SCALAR_MAX32 = 32'h0010FFFF;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one input item's worth of results: cnt-1 replacement beats, then cp/bad
    typedef struct packed {
        logic [2:0]  cnt;
        logic [20:0] cp;
        logic        bad;
    } t_cmd;

endpackage

>>> hw/rtl/ucd_front.sv
// front end: encoding register, sequence state and per-item classification
// depends on ucd_pkg
module ucd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_data,
    input  logic                i_valid,
    input  logic [31:0]         i_unit,
    input  logic                i_eot,
    input  logic                i_full,
    output logic                o_ready,
    output logic                o_push,
    output ucd_pkg::t_cmd       o_cmd
);

    logic [1:0]  r_enc;
    logic [2:0]  r_exp;
    logic [1:0]  r_held;
    logic [20:0] r_part;

    logic [2:0]  n_exp;
    logic [1:0]  n_held;
    logic [20:0] n_part;
    ucd_pkg::t_cmd cmd;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] w;
    logic [2:0]  count;
    logic [20:0] v8;
    logic        ok;
    logic        fresh;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign b       = i_unit[7:0];
    assign w       = i_unit[15:0];
    assign count   = {1'b0, r_held} + 3'd1;
    assign v8      = {r_part[14:0], b[5:0]};

    always_comb begin
        n_exp   = r_exp;
        n_held  = r_held;
        n_part  = r_part;
        cmd.cnt = 3'd0;
        cmd.cp  = ucd_pkg::REPLACEMENT;
        cmd.bad = 1'b1;
        fresh   = 1'b0;
        ok      = 1'b0;
        unique case (r_enc)
            ucd_pkg::ENC_UTF8: begin
                if (r_exp != 3'd0) begin
                    if (b[7:6] == 2'b10) begin
                        if (count < r_exp) begin
                            n_held = count[1:0];
                            n_part = v8;
                        end else begin
                            if (r_exp == 3'd2) begin
                                ok = 1'b1;
                            end else if (r_exp == 3'd3) begin
                                ok = (v8 >= ucd_pkg::MIN_3BYTE) &&
                                     !(v8 >= 21'(ucd_pkg::HI_SURR_LO) &&
                                       v8 <= 21'(ucd_pkg::LO_SURR_HI));
                            end else begin
                                ok = (v8 >= ucd_pkg::MIN_4BYTE) &&
                                     (v8 <= ucd_pkg::MAX_SCALAR);
                            end
                            if (ok) begin
                                cmd.cnt = 3'd1;
                                cmd.cp  = v8;
                                cmd.bad = 1'b0;
                            end else begin
                                cmd.cnt = count;
                            end
                            n_exp  = 3'd0;
                            n_held = 2'd0;
                            n_part = '0;
                        end
                    end else begin
                        cmd.cnt = {1'b0, r_held};
                        n_exp   = 3'd0;
                        n_held  = 2'd0;
                        n_part  = '0;
                        fresh   = 1'b1;
                    end
                end else begin
                    fresh = 1'b1;
                end
                if (fresh) begin
                    if (b[7] == 1'b0) begin
                        cmd.cnt = cmd.cnt + 3'd1;
                        cmd.cp  = {13'd0, b};
                        cmd.bad = 1'b0;
                    end else if (b >= ucd_pkg::LEAD2_LO && b <= ucd_pkg::LEAD2_HI) begin
                        n_exp  = 3'd2;
                        n_held = 2'd1;
                        n_part = {16'd0, b[4:0]};
                    end else if (b >= ucd_pkg::LEAD3_LO && b <= ucd_pkg::LEAD3_HI) begin
                        n_exp  = 3'd3;
                        n_held = 2'd1;
                        n_part = {17'd0, b[3:0]};
                    end else if (b >= ucd_pkg::LEAD4_LO && b <= ucd_pkg::LEAD4_HI) begin
                        n_exp  = 3'd4;
                        n_held = 2'd1;
                        n_part = {18'd0, b[2:0]};
                    end else begin
                        cmd.cnt = cmd.cnt + 3'd1;
                    end
                end
            end
            ucd_pkg::ENC_UTF16: begin
                if (r_exp != 3'd0) begin
                    if (w >= ucd_pkg::LO_SURR_LO && w <= ucd_pkg::LO_SURR_HI) begin
                        // high surrogate's low ten bits hold the upper half
                        cmd.cnt = 3'd1;
                        cmd.cp  = {1'b0, r_part[9:0], w[9:0]} + ucd_pkg::MIN_4BYTE;
                        cmd.bad = 1'b0;
                        n_exp   = 3'd0;
                        n_held  = 2'd0;
                        n_part  = '0;
                    end else begin
                        cmd.cnt = {1'b0, r_held};
                        n_exp   = 3'd0;
                        n_held  = 2'd0;
                        n_part  = '0;
                        fresh   = 1'b1;
                    end
                end else begin
                    fresh = 1'b1;
                end
                if (fresh) begin
                    if (w >= ucd_pkg::HI_SURR_LO && w <= ucd_pkg::HI_SURR_HI) begin
                        n_exp  = 3'd2;
                        n_held = 2'd1;
                        n_part = {5'd0, w};
                    end else if (w >= ucd_pkg::LO_SURR_LO && w <= ucd_pkg::LO_SURR_HI) begin
                        cmd.cnt = cmd.cnt + 3'd1;
                    end else begin
                        cmd.cnt = cmd.cnt + 3'd1;
                        cmd.cp  = {5'd0, w};
                        cmd.bad = 1'b0;
                    end
                end
            end
            default: begin
                cmd.cnt = 3'd1;
                if (i_unit <= ucd_pkg::SCALAR_MAX32 &&
                    !(i_unit >= 32'(ucd_pkg::HI_SURR_LO) &&
                      i_unit <= 32'(ucd_pkg::LO_SURR_HI))) begin
                    cmd.cp  = i_unit[20:0];
                    cmd.bad = 1'b0;
                end
            end
        endcase
        // end of text flushes whatever sequence is still open
        if (i_eot && n_exp != 3'd0) begin
            cmd.cnt = cmd.cnt + {1'b0, n_held};
            cmd.cp  = ucd_pkg::REPLACEMENT;
            cmd.bad = 1'b1;
            n_exp   = 3'd0;
            n_held  = 2'd0;
            n_part  = '0;
        end
    end

    assign o_push = accept && (cmd.cnt != 3'd0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc  <= ucd_pkg::ENC_UTF8;
            r_exp  <= 3'd0;
            r_held <= 2'd0;
            r_part <= '0;
        end else if (i_cfg_valid) begin
            r_enc  <= i_cfg_data;
            r_exp  <= 3'd0;
            r_held <= 2'd0;
            r_part <= '0;
        end else if (accept) begin
            r_exp  <= n_exp;
            r_held <= n_held;
            r_part <= n_part;
        end
    end

`ifndef SYNTHESIS
    // held count always stays below the sequence length
    a_held_below_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp != 3'd0) |-> ({1'b0, r_held} < r_exp && r_held != 2'd0))
        else $error("held unit count out of range");
    a_closed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp == 3'd0) |-> (r_held == 2'd0))
        else $error("units held with no open sequence");
    a_eot_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_eot && !i_cfg_valid) |=> (r_exp == 3'd0))
        else $error("sequence left open after end of text");
    a_cmd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (cmd.cnt <= 3'd4))
        else $error("more than four results for one unit");
`endif

endmodule

>>> hw/rtl/ucd_queue.sv
// short command queue between the front end and the result expander
// depends on ucd_pkg
module ucd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ucd_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output ucd_pkg::t_cmd  o_head
);

    ucd_pkg::t_cmd r_mem [ucd_pkg::QUEUE_DEPTH];
    logic [ucd_pkg::QUEUE_AW-1:0] r_wr;
    logic [ucd_pkg::QUEUE_AW-1:0] r_rd;
    logic [ucd_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (ucd_pkg::QUEUE_AW+1)'(ucd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + (ucd_pkg::QUEUE_AW)'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + (ucd_pkg::QUEUE_AW)'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (ucd_pkg::QUEUE_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (ucd_pkg::QUEUE_AW+1)'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_nonzero_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_cmd.cnt != 3'd0))
        else $error("command with no results queued");
`endif

endmodule

>>> hw/rtl/ucd_back.sv
// back end: expands each queued command into its result beats
// depends on ucd_pkg
module ucd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  ucd_pkg::t_cmd  i_head,
    output logic           o_pop,
    input  logic           i_tready,
    output logic           o_tvalid,
    output logic [20:0]    o_cp,
    output logic           o_bad,
    output logic           o_last
);

    logic        r_valid;
    logic [2:0]  r_rem;
    logic [20:0] r_cp;
    logic        r_bad;
    logic        load;
    logic        fin;

    assign fin    = (r_rem == 3'd1);
    assign load   = !r_valid || (i_tready && fin);
    assign o_pop  = load && !i_empty;

    assign o_tvalid = r_valid;
    assign o_cp     = fin ? r_cp : ucd_pkg::REPLACEMENT;
    assign o_bad    = fin ? r_bad : 1'b1;
    assign o_last   = fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rem   <= 3'd0;
        end else if (load) begin
            r_valid <= !i_empty;
            r_rem   <= i_head.cnt;
        end else if (i_tready) begin
            r_rem <= r_rem - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cp  <= i_head.cp;
            r_bad <= i_head.bad;
        end
    end

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_rem != 3'd0 && r_rem <= 3'd4))
        else $error("beat count out of range");
    a_early_beats_faulty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !fin) |-> (o_bad && o_cp == ucd_pkg::REPLACEMENT))
        else $error("non-final beat is not a replacement");
    a_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_tready && !fin) |=> (r_valid && r_rem == $past(r_rem) - 3'd1))
        else $error("beat countdown slipped");
`endif

endmodule

>>> hw/rtl/utf_codepoint_decoder_unit.sv
// top level of the utf-8/utf-16/utf-32 code point decoder
// depends on ucd_pkg, ucd_front, ucd_queue, ucd_back
//
// channel  direction  handshake                 payload
// s_axis   in         i_tvalid / o_tready       i_tdata code unit, i_tlast end of text
// m_axis   out        o_tvalid / i_tready       o_tdata code point, o_tuser faulty, o_tlast
// cfg      in         i_cfg_valid / o_cfg_ready i_cfg_data encoding
//
// one code unit is taken per cycle while the four-entry command queue has room
// each unit gives 0 to 4 result beats; the output side sends one beat a cycle while i_tready is high
// reset clears the open sequence, the queue and the output register; encoding is utf-8
// a stalled output fills the queue and then drops o_tready
module utf_codepoint_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,    // encoding
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [31:0] i_tdata,       // [31:0] code_unit
    input  logic        i_tlast,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [23:0] o_tdata,       // [20:0] code_point, [23:21] zero
    output logic        o_tuser,       // [0] faulty
    output logic        o_tlast
);

    ucd_pkg::t_cmd push_cmd;
    ucd_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    logic [20:0]   cp;

    assign o_cfg_ready = 1'b1;

    ucd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_tvalid),
        .i_unit      (i_tdata),
        .i_eot       (i_tlast),
        .i_full      (full),
        .o_ready     (o_tready),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    ucd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_cmd)
    );

    ucd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head_cmd),
        .o_pop    (pop),
        .i_tready (i_tready),
        .o_tvalid (o_tvalid),
        .o_cp     (cp),
        .o_bad    (o_tuser),
        .o_last   (o_tlast)
    );

    assign o_tdata = {3'd0, cp};

endmodule
